// ----- rtl/ght_pkg.sv -----
package ght_pkg;

    localparam int HANDLE_W     = 32;
    localparam int ACTION_W     = 3;
    localparam int SLOT_INDEX_W = 10;
    localparam int MAP_SIZE_W   = 10;

    localparam int ENTRIES_DEFAULT      = 1024;
    localparam int INDEX_BITS_DEFAULT   = 10;
    localparam int OBJECT_WIDTH_DEFAULT = 64;

    localparam logic [MAP_SIZE_W-1:0] MAP_SIZE_RESET = 10'd1022;

    typedef enum logic [ACTION_W-1:0] {
        ACT_RESERVE    = 3'd0,
        ACT_FREE       = 3'd1,
        ACT_SET        = 3'd2,
        ACT_ACQUIRE    = 3'd3,
        ACT_RELEASE    = 3'd4,
        ACT_RAW_LOOKUP = 3'd5
    } ght_action_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } ght_state_t;

    typedef struct packed {
        logic load;
        logic exec;
    } ght_cmd_t;

    typedef struct packed {
        logic out_free;
    } ght_status_t;

endpackage

// ----- rtl/ght_ctrl.sv -----
module ght_ctrl import ght_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  ght_status_t status,
    output ght_cmd_t    cmd
);

    ght_state_t state_reg;
    ght_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready  = 1'b0;
        cmd.load = 1'b0;
        cmd.exec = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_EXEC: begin
                cmd.exec = status.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

// ----- rtl/ght_datapath.sv -----
module ght_datapath import ght_pkg::*; #(
    parameter int ENTRIES      = ENTRIES_DEFAULT,
    parameter int INDEX_BITS   = INDEX_BITS_DEFAULT,
    parameter int OBJECT_WIDTH = OBJECT_WIDTH_DEFAULT
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [MAP_SIZE_W-1:0]   cfg_wr_data,
    input  logic [ACTION_W-1:0]     s_action,
    input  logic [HANDLE_W-1:0]     s_handle,
    input  logic [OBJECT_WIDTH-1:0] s_object_value,
    input  logic [SLOT_INDEX_W-1:0] s_slot_index,
    input  ght_cmd_t                cmd,
    output ght_status_t             status,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_ok,
    output logic [HANDLE_W-1:0]     m_handle_out,
    output logic [OBJECT_WIDTH-1:0] m_object_out,
    output logic                    m_dealloc_request
);

    localparam int AW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int TAG_W  = HANDLE_W - INDEX_BITS;
    localparam int ENT_W  = HANDLE_W + OBJECT_WIDTH;
    localparam int FILL_W = AW + 1;
    localparam logic [31:0] ENTRIES_L = 32'(ENTRIES);

    logic [ENT_W-1:0] slot_mem [ENTRIES];

    logic [MAP_SIZE_W-1:0]   map_size_reg;
    logic [INDEX_BITS-1:0]   free_head_reg, free_head_next;
    logic [INDEX_BITS-1:0]   high_water_reg, high_water_next;
    logic [TAG_W-1:0]        tag_counter_reg, tag_counter_next;
    logic [FILL_W-1:0]       fill_reg;

    logic [ACTION_W-1:0]     action_reg;
    logic [HANDLE_W-1:0]     handle_reg;
    logic [OBJECT_WIDTH-1:0] object_reg;
    logic [SLOT_INDEX_W-1:0] sidx_reg;
    logic                    range_ok_reg;
    logic                    hit_reg;
    logic [AW-1:0]           addr_reg;
    logic [ENT_W-1:0]        rdata_reg;

    logic                    m_valid_reg;
    logic                    m_ok_reg;
    logic [HANDLE_W-1:0]     m_handle_out_reg;
    logic [OBJECT_WIDTH-1:0] m_object_out_reg;
    logic                    m_dealloc_request_reg;

    logic [31:0]             target;
    logic                    range_ok;
    logic                    hit;

    logic [HANDLE_W-1:0]     ref_w;
    logic [OBJECT_WIDTH-1:0] slot_obj;
    logic [TAG_W-1:0]        ref_tag;
    logic [TAG_W-1:0]        h_tag;
    logic [INDEX_BITS-1:0]   cnt;
    logic [INDEX_BITS-1:0]   idx;
    logic [TAG_W-1:0]        tag_inc;
    logic [TAG_W-1:0]        new_tag;
    logic [INDEX_BITS-1:0]   hw_inc;
    logic                    lazy;
    logic                    tag_match;

    logic                    wr_en;
    logic [ENT_W-1:0]        wr_data;
    logic                    ok;
    logic [HANDLE_W-1:0]     hout;
    logic [OBJECT_WIDTH-1:0] oout;
    logic                    dealloc;

    // The slot an action addresses is chosen as the word is accepted.
    always_comb begin
        case (s_action)
            ACT_RESERVE:    target = 32'(free_head_reg);
            ACT_RAW_LOOKUP: target = 32'(s_slot_index);
            default:        target = 32'(s_handle[INDEX_BITS-1:0]);
        endcase
        range_ok = (target < ENTRIES_L) &&
                   ((s_action == ACT_RAW_LOOKUP) || (target < 32'(map_size_reg)));
        hit = target < 32'(fill_reg);
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            action_reg   <= s_action;
            handle_reg   <= s_handle;
            object_reg   <= s_object_value;
            sidx_reg     <= s_slot_index;
            range_ok_reg <= range_ok;
            hit_reg      <= hit;
            addr_reg     <= target[AW-1:0];
            rdata_reg    <= slot_mem[target[AW-1:0]];
        end
        if (wr_en) begin
            slot_mem[addr_reg] <= wr_data;
        end
    end

    always_comb begin
        ref_w     = hit_reg ? rdata_reg[ENT_W-1:OBJECT_WIDTH] : '0;
        slot_obj  = hit_reg ? rdata_reg[OBJECT_WIDTH-1:0] : '0;
        ref_tag   = ref_w[HANDLE_W-1:INDEX_BITS];
        cnt       = ref_w[INDEX_BITS-1:0];
        h_tag     = handle_reg[HANDLE_W-1:INDEX_BITS];
        idx       = handle_reg[INDEX_BITS-1:0];
        tag_match = ref_tag == h_tag;
        tag_inc   = tag_counter_reg + 1'b1;
        new_tag   = (tag_inc == '0) ? TAG_W'(1) : tag_inc;
        hw_inc    = high_water_reg + 1'b1;
        lazy      = free_head_reg >= high_water_reg;

        wr_en            = 1'b0;
        wr_data          = {ref_w, slot_obj};
        free_head_next   = free_head_reg;
        high_water_next  = high_water_reg;
        tag_counter_next = tag_counter_reg;
        ok               = 1'b0;
        hout             = '0;
        oout             = '0;
        dealloc          = 1'b0;

        case (action_reg)
            ACT_RESERVE: begin
                if (range_ok_reg) begin
                    wr_en            = 1'b1;
                    wr_data          = {new_tag, {INDEX_BITS{1'b0}}, {OBJECT_WIDTH{1'b0}}};
                    free_head_next   = lazy ? hw_inc : slot_obj[INDEX_BITS-1:0];
                    high_water_next  = lazy ? hw_inc : high_water_reg;
                    tag_counter_next = new_tag;
                    ok               = 1'b1;
                    hout             = {new_tag, free_head_reg};
                end
            end
            ACT_FREE: begin
                if (range_ok_reg && (ref_tag != '0) && tag_match) begin
                    wr_en          = 1'b1;
                    wr_data        = {{HANDLE_W{1'b0}}, OBJECT_WIDTH'(free_head_reg)};
                    free_head_next = idx;
                    ok             = 1'b1;
                end
            end
            ACT_SET: begin
                if (range_ok_reg && (ref_tag != '0) && (slot_obj == '0) && tag_match &&
                    (cnt == '0)) begin
                    wr_en   = 1'b1;
                    wr_data = {ref_tag, INDEX_BITS'(1), object_reg};
                    ok      = 1'b1;
                end
            end
            ACT_ACQUIRE: begin
                if (range_ok_reg && tag_match && (cnt != '0) && (cnt != '1)) begin
                    wr_en   = 1'b1;
                    wr_data = {ref_tag, cnt + 1'b1, slot_obj};
                    ok      = 1'b1;
                    oout    = slot_obj;
                end
            end
            ACT_RELEASE: begin
                if (range_ok_reg && tag_match && (cnt != '0)) begin
                    wr_en   = 1'b1;
                    wr_data = {ref_tag, cnt - 1'b1, slot_obj};
                    ok      = 1'b1;
                    if (cnt == INDEX_BITS'(1)) begin
                        dealloc = 1'b1;
                        oout    = slot_obj;
                        if (ref_tag != '0) begin
                            wr_data        = {{HANDLE_W{1'b0}}, OBJECT_WIDTH'(free_head_reg)};
                            free_head_next = idx;
                        end
                    end
                end
            end
            ACT_RAW_LOOKUP: begin
                if (range_ok_reg && (ref_w != '0)) begin
                    ok   = 1'b1;
                    hout = {ref_tag, INDEX_BITS'(sidx_reg)};
                    oout = slot_obj;
                end
            end
            default: begin
                ok = 1'b0;
            end
        endcase

        wr_en = wr_en && cmd.exec;
    end

    // Slots at or above the fill count were never written and read as zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_size_reg    <= MAP_SIZE_RESET;
            free_head_reg   <= '0;
            high_water_reg  <= '0;
            tag_counter_reg <= '0;
            fill_reg        <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                map_size_reg <= cfg_wr_data;
            end
            if (cmd.exec) begin
                free_head_reg   <= free_head_next;
                high_water_reg  <= high_water_next;
                tag_counter_reg <= tag_counter_next;
                m_valid_reg     <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (wr_en && ({1'b0, addr_reg} >= fill_reg)) begin
                fill_reg <= {1'b0, addr_reg} + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            m_ok_reg              <= ok;
            m_handle_out_reg      <= hout;
            m_object_out_reg      <= oout;
            m_dealloc_request_reg <= dealloc;
        end
    end

    assign status.out_free   = !m_valid_reg || m_ready;
    assign m_valid           = m_valid_reg;
    assign m_ok              = m_ok_reg;
    assign m_handle_out      = m_handle_out_reg;
    assign m_object_out      = m_object_out_reg;
    assign m_dealloc_request = m_dealloc_request_reg;

    a_exec_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |-> (!m_valid_reg || m_ready))
        else $error("result committed while the output word was still held");

    a_exec_shows_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |=> m_valid_reg)
        else $error("committed result not presented");

    a_fill_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(fill_reg) <= ENTRIES_L)
        else $error("fill count beyond the table depth");

    a_write_no_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> ({1'b0, addr_reg} <= fill_reg))
        else $error("slot write leaves unwritten slots below it");

    a_dealloc_is_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && dealloc) |-> (ok && (action_reg == ACT_RELEASE)))
        else $error("deallocation request outside a successful release");

endmodule

// ----- rtl/generational_handle_table.sv -----
// Each input word is captured as it is accepted; its result is written to the output register
// from the execute state, once the output register is empty or being drained.
// No new word is taken until the previous one has executed; the slot memory is read in the accept cycle
// and written back from the execute state through its single write port.
// Reset (aresetn, synchronous, active low) clears the control state and the fill count,
// so every slot reads as zero at once; no clearing pass runs over the memory.
module generational_handle_table import ght_pkg::*; #(
    parameter int ENTRIES      = ENTRIES_DEFAULT,
    parameter int INDEX_BITS   = INDEX_BITS_DEFAULT,
    parameter int OBJECT_WIDTH = OBJECT_WIDTH_DEFAULT
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [MAP_SIZE_W-1:0]   cfg_wr_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [ACTION_W-1:0]     s_action,
    input  logic [HANDLE_W-1:0]     s_handle,
    input  logic [OBJECT_WIDTH-1:0] s_object_value,
    input  logic [SLOT_INDEX_W-1:0] s_slot_index,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_ok,
    output logic [HANDLE_W-1:0]     m_handle_out,
    output logic [OBJECT_WIDTH-1:0] m_object_out,
    output logic                    m_dealloc_request
);

    ght_cmd_t    cmd;
    ght_status_t status;

    ght_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    ght_datapath #(
        .ENTRIES      (ENTRIES),
        .INDEX_BITS   (INDEX_BITS),
        .OBJECT_WIDTH (OBJECT_WIDTH)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_action          (s_action),
        .s_handle          (s_handle),
        .s_object_value    (s_object_value),
        .s_slot_index      (s_slot_index),
        .cmd               (cmd),
        .status            (status),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_ok              (m_ok),
        .m_handle_out      (m_handle_out),
        .m_object_out      (m_object_out),
        .m_dealloc_request (m_dealloc_request)
    );

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import ght_pkg::*;

    localparam int IB      = INDEX_BITS_DEFAULT;
    localparam int OBJ_W   = OBJECT_WIDTH_DEFAULT;
    localparam int NSLOT   = ENTRIES_DEFAULT;
    localparam int TAG_W   = HANDLE_W - IB;
    localparam int CYCLE_LIMIT = 600000;
    localparam int MAX_GAP = 40;

    localparam logic [ACTION_W-1:0] ACT_BAD_LO = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_BAD_HI = 3'd7;
    localparam logic [OBJ_W-1:0]    OBJ_ONES   = '1;

    typedef struct packed {
        logic [ACTION_W-1:0]     action;
        logic [HANDLE_W-1:0]     handle;
        logic [OBJ_W-1:0]        obj_val;
        logic [SLOT_INDEX_W-1:0] slot;
    } table_cmd_t;

    typedef struct packed {
        logic                ok;
        logic [HANDLE_W-1:0] handle_out;
        logic [OBJ_W-1:0]    object_out;
        logic                dealloc;
    } table_rsp_t;

    typedef struct packed {
        table_cmd_t cmd;
        logic       lit;
        table_rsp_t rsp;
    } table_row_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [MAP_SIZE_W-1:0]   cfg_wr_data = '0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [ACTION_W-1:0]     s_action = '0;
    logic [HANDLE_W-1:0]     s_handle = '0;
    logic [OBJ_W-1:0]        s_object_value = '0;
    logic [SLOT_INDEX_W-1:0] s_slot_index = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic                    m_ok;
    logic [HANDLE_W-1:0]     m_handle_out;
    logic [OBJ_W-1:0]        m_object_out;
    logic                    m_dealloc_request;

    logic [HANDLE_W-1:0]   slot_ref [0:NSLOT-1];
    logic [OBJ_W-1:0]      slot_obj [0:NSLOT-1];
    logic [IB-1:0]         head_idx;
    logic [IB-1:0]         hw_idx;
    logic [TAG_W-1:0]      tag_ctr;
    logic [MAP_SIZE_W-1:0] map_limit;

    table_rsp_t          pending_results [$];
    table_row_t          directed_rows [$];
    logic [HANDLE_W-1:0] handle_pool [$];
    table_rsp_t          last_rsp;
    int unsigned         send_idle_pct = 0;
    int unsigned         recv_stall_pct = 0;
    int unsigned         n_err = 0;
    int unsigned         cycle_cnt = 0;

    generational_handle_table #(
        .ENTRIES      (NSLOT),
        .INDEX_BITS   (IB),
        .OBJECT_WIDTH (OBJ_W)
    ) u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_action          (s_action),
        .s_handle          (s_handle),
        .s_object_value    (s_object_value),
        .s_slot_index      (s_slot_index),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_ok              (m_ok),
        .m_handle_out      (m_handle_out),
        .m_object_out      (m_object_out),
        .m_dealloc_request (m_dealloc_request)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic free_slot(input logic [HANDLE_W-1:0] h);
        logic [IB-1:0]       idx;
        logic [HANDLE_W-1:0] rw;
        idx = h[IB-1:0];
        rw = slot_ref[idx];
        if (idx >= map_limit || rw[HANDLE_W-1:IB] == '0 || rw[HANDLE_W-1:IB] != h[HANDLE_W-1:IB])
            return 1'b0;
        slot_obj[idx] = OBJ_W'(head_idx);
        head_idx = idx;
        slot_ref[idx] = '0;
        return 1'b1;
    endfunction

    function automatic table_rsp_t step_table(input table_cmd_t c);
        table_rsp_t          r;
        logic [IB-1:0]       idx;
        logic [IB-1:0]       nxt;
        logic [IB-1:0]       cnt;
        logic [HANDLE_W-1:0] rw;
        logic                tag_hit;
        logic                in_map;
        r = '0;
        idx = c.handle[IB-1:0];
        rw = slot_ref[idx];
        cnt = rw[IB-1:0];
        tag_hit = (rw[HANDLE_W-1:IB] == c.handle[HANDLE_W-1:IB]);
        in_map = (idx < map_limit);
        case (c.action)
            ACT_RESERVE: begin
                idx = head_idx;
                if (idx < map_limit) begin
                    if (idx >= hw_idx) begin
                        hw_idx = hw_idx + 1'b1;
                        nxt = hw_idx;
                    end else begin
                        nxt = slot_obj[idx][IB-1:0];
                    end
                    head_idx = nxt;
                    slot_obj[idx] = '0;
                    tag_ctr = tag_ctr + 1'b1;
                    if (tag_ctr == '0)
                        tag_ctr = TAG_W'(1);
                    slot_ref[idx] = {tag_ctr, {IB{1'b0}}};
                    r.ok = 1'b1;
                    r.handle_out = {tag_ctr, idx};
                end
            end
            ACT_FREE: begin
                r.ok = free_slot(c.handle);
            end
            ACT_SET: begin
                if (in_map && rw[HANDLE_W-1:IB] != '0 && slot_obj[idx] == '0 && tag_hit
                        && cnt == '0) begin
                    slot_obj[idx] = c.obj_val;
                    slot_ref[idx] = rw | 1;
                    r.ok = 1'b1;
                end
            end
            ACT_ACQUIRE: begin
                if (in_map && tag_hit && cnt != '0 && cnt != '1) begin
                    slot_ref[idx] = {rw[HANDLE_W-1:IB], cnt + 1'b1};
                    r.ok = 1'b1;
                    r.object_out = slot_obj[idx];
                end
            end
            ACT_RELEASE: begin
                if (in_map && tag_hit && cnt != '0) begin
                    slot_ref[idx] = {rw[HANDLE_W-1:IB], cnt - 1'b1};
                    r.ok = 1'b1;
                    if (cnt == 1) begin
                        r.dealloc = 1'b1;
                        r.object_out = slot_obj[idx];
                        void'(free_slot(c.handle));
                    end
                end
            end
            ACT_RAW_LOOKUP: begin
                rw = slot_ref[c.slot];
                if (rw != '0) begin
                    r.ok = 1'b1;
                    r.handle_out = {rw[HANDLE_W-1:IB], c.slot[IB-1:0]};
                    r.object_out = slot_obj[c.slot];
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic table_cmd_t mk_cmd(input logic [ACTION_W-1:0] action,
                                          input logic [HANDLE_W-1:0] handle,
                                          input logic [OBJ_W-1:0] obj_val,
                                          input logic [SLOT_INDEX_W-1:0] slot);
        table_cmd_t c;
        c.action = action;
        c.handle = handle;
        c.obj_val = obj_val;
        c.slot = slot;
        return c;
    endfunction

    task automatic add_row(input logic [ACTION_W-1:0] action,
                           input logic [HANDLE_W-1:0] handle,
                           input logic [OBJ_W-1:0] obj_val,
                           input logic [SLOT_INDEX_W-1:0] slot,
                           input logic lit, input logic ok,
                           input logic [HANDLE_W-1:0] hout,
                           input logic [OBJ_W-1:0] oout, input logic dealloc);
        table_row_t row;
        row.cmd = mk_cmd(action, handle, obj_val, slot);
        row.lit = lit;
        row.rsp.ok = ok;
        row.rsp.handle_out = hout;
        row.rsp.object_out = oout;
        row.rsp.dealloc = dealloc;
        directed_rows.push_back(row);
    endtask

    task automatic send_word(input table_cmd_t c, input logic lit, input table_rsp_t want);
        int unsigned gap;
        table_rsp_t  r;
        gap = 0;
        while (send_idle_pct != 0 && gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= c.action;
        s_handle <= c.handle;
        s_object_value <= c.obj_val;
        s_slot_index <= c.slot;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        r = step_table(c);
        last_rsp = r;
        pending_results.push_back(lit ? want : r);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_map_size(input logic [MAP_SIZE_W-1:0] v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        map_limit = v;
    endtask

    function automatic table_cmd_t make_random_cmd();
        table_cmd_t          c;
        int unsigned         pick;
        logic [HANDLE_W-1:0] h;
        c = mk_cmd(ACT_RAW_LOOKUP, $urandom, {$urandom, $urandom}, SLOT_INDEX_W'($urandom));
        h = (handle_pool.size() != 0) ? handle_pool[$urandom_range(handle_pool.size() - 1)]
                                      : HANDLE_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 20) begin
            c.action = ACT_RESERVE;
        end else if (pick < 35) begin
            c.action = ACT_SET;
            c.handle = h;
        end else if (pick < 55) begin
            c.action = ACT_ACQUIRE;
            c.handle = h;
        end else if (pick < 75) begin
            c.action = ACT_RELEASE;
            c.handle = h;
        end else if (pick < 82) begin
            c.action = ACT_FREE;
            c.handle = h;
        end else if (pick < 90) begin
            if ($urandom_range(1) == 0)
                c.slot = SLOT_INDEX_W'($urandom_range(15));
        end else begin
            c.action = ACTION_W'($urandom);
            if ($urandom_range(1) == 0)
                c.handle = h ^ (32'h1 << $urandom_range(HANDLE_W - 1));
        end
        case ($urandom_range(7))
            0: c.obj_val = '0;
            1: c.obj_val = OBJ_ONES;
            default: begin
            end
        endcase
        return c;
    endfunction

    task automatic run_random_phase(input logic [MAP_SIZE_W-1:0] limit,
                                    input int unsigned send_pct, input int unsigned recv_pct,
                                    input int unsigned n);
        table_cmd_t c;
        drain_results();
        write_map_size(limit);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        repeat (n) begin
            c = make_random_cmd();
            send_word(c, 1'b0, '0);
            if (c.action == ACT_RESERVE && last_rsp.ok) begin
                handle_pool.push_back(last_rsp.handle_out);
                if (handle_pool.size() > 12)
                    void'(handle_pool.pop_front());
            end
        end
    endtask

    task automatic check_field(input string what, input logic [OBJ_W-1:0] want,
                               input logic [OBJ_W-1:0] got);
        if (got !== want) begin
            n_err++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
        end
    endtask

    always @(posedge aclk) begin : rsp_check
        table_rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                n_err++;
                $display("%0t: unexpected word, expected none, actual ok=%b h=%h obj=%h dl=%b",
                         $time, m_ok, m_handle_out, m_object_out, m_dealloc_request);
            end else begin
                want = pending_results.pop_front();
                check_field("ok", OBJ_W'(want.ok), OBJ_W'(m_ok));
                check_field("handle_out", OBJ_W'(want.handle_out), OBJ_W'(m_handle_out));
                check_field("object_out", want.object_out, m_object_out);
                check_field("dealloc_request", OBJ_W'(want.dealloc), OBJ_W'(m_dealloc_request));
            end
        end
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        table_cmd_t          c;
        logic [HANDLE_W-1:0] h;
        for (int i = 0; i < NSLOT; i++) begin
            slot_ref[i] = '0;
            slot_obj[i] = '0;
        end
        head_idx = '0;
        hw_idx = '0;
        tag_ctr = '0;
        map_limit = MAP_SIZE_RESET;

        add_row(ACT_RAW_LOOKUP, 32'h0, '0, 10'd0, 1, 0, 32'h0, '0, 0);
        add_row(ACT_RESERVE, 32'h0, '0, 10'd0, 1, 1, 32'h400, '0, 0);
        add_row(ACT_RESERVE, 32'h0, '0, 10'd0, 1, 1, 32'h801, '0, 0);
        add_row(ACT_SET, 32'h400, OBJ_ONES, 10'd0, 1, 1, 32'h0, '0, 0);
        add_row(ACT_SET, 32'h400, 64'h5, 10'd0, 1, 0, 32'h0, '0, 0);
        add_row(ACT_ACQUIRE, 32'h400, '0, 10'd0, 1, 1, 32'h0, OBJ_ONES, 0);
        add_row(ACT_RAW_LOOKUP, 32'h0, '0, 10'd0, 1, 1, 32'h400, OBJ_ONES, 0);
        add_row(ACT_RELEASE, 32'h400, '0, 10'd0, 1, 1, 32'h0, '0, 0);
        add_row(ACT_RELEASE, 32'h400, '0, 10'd0, 1, 1, 32'h0, OBJ_ONES, 1);
        add_row(ACT_RELEASE, 32'h400, '0, 10'd0, 1, 0, 32'h0, '0, 0);
        add_row(ACT_FREE, 32'h400, '0, 10'd0, 1, 0, 32'h0, '0, 0);
        add_row(ACT_SET, 32'h400, 64'h7, 10'd0, 1, 0, 32'h0, '0, 0);
        add_row(ACT_ACQUIRE, 32'hC01, '0, 10'd0, 1, 0, 32'h0, '0, 0);
        add_row(ACT_ACQUIRE, 32'h801, '0, 10'd0, 1, 0, 32'h0, '0, 0);
        add_row(ACT_SET, 32'h801, '0, 10'd0, 1, 1, 32'h0, '0, 0);
        add_row(ACT_ACQUIRE, 32'h801, '0, 10'd0, 1, 1, 32'h0, '0, 0);
        add_row(ACT_FREE, 32'h801, '0, 10'd0, 1, 1, 32'h0, '0, 0);
        add_row(ACT_RESERVE, 32'h0, '0, 10'd0, 0, 0, 32'h0, '0, 0);
        add_row(ACT_RESERVE, 32'h0, '0, 10'd0, 0, 0, 32'h0, '0, 0);
        add_row(ACT_SET, 32'h1000, 64'hA5A5_5A5A_0123_4567, 10'd0, 0, 0, 32'h0, '0, 0);
        add_row(ACT_ACQUIRE, 32'hFFFF_FFFF, OBJ_ONES, 10'd1023, 1, 0, 32'h0, '0, 0);
        add_row(ACT_RELEASE, 32'h3FE, '0, 10'd0, 1, 0, 32'h0, '0, 0);
        add_row(ACT_FREE, 32'h3FF, '0, 10'd0, 1, 0, 32'h0, '0, 0);
        add_row(ACT_BAD_LO, 32'h1000, '0, 10'd0, 1, 0, 32'h0, '0, 0);
        add_row(ACT_BAD_HI, 32'h1000, '0, 10'd0, 1, 0, 32'h0, '0, 0);
        add_row(ACT_RAW_LOOKUP, 32'h0, '0, 10'd1023, 1, 0, 32'h0, '0, 0);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            send_word(directed_rows[i].cmd, directed_rows[i].lit, directed_rows[i].rsp);

        // Drive one slot up to its largest count and past it.
        c = mk_cmd(ACT_RESERVE, '0, '0, '0);
        send_word(c, 1'b0, '0);
        h = last_rsp.handle_out;
        send_word(mk_cmd(ACT_SET, h, {$urandom, $urandom}, '0), 1'b0, '0);
        repeat ((1 << IB) - 1) send_word(mk_cmd(ACT_ACQUIRE, h, '0, '0), 1'b0, '0);
        send_word(mk_cmd(ACT_RELEASE, h, '0, '0), 1'b0, '0);
        send_word(mk_cmd(ACT_ACQUIRE, h, '0, '0), 1'b0, '0);
        send_word(mk_cmd(ACT_FREE, h, '0, '0), 1'b0, '0);

        run_random_phase(10'd3, 0, 0, 12);
        run_random_phase(10'd1022, 78, 0, 14);
        run_random_phase(10'd517, 0, 78, 14);
        run_random_phase(10'd8, 10, 10, 10);
        run_random_phase(10'd1022, 0, 78, 10);
        run_random_phase(10'd64, 78, 0, 10);

        drain_results();
        if (n_err == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
